@@ src/sha1md_pkg.sv @@
// Shared types and constants for the SHA-1 message digest core.
// No dependencies; every other source file refers to it by scoped name.
`default_nettype none

package sha1md_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_H      = 5;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned ROUNDS     = 80;
  localparam int unsigned RND_W      = 7;
  localparam int unsigned WIN_DEPTH  = 16;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned LEN_W      = 64;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = 2;
  localparam int unsigned Q_CNT_W    = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = 3'd4;
  localparam logic [7:0]       PAD_BYTE = 8'h80;
  localparam logic [POS_W-1:0] LEN_POS  = 6'd56;
  localparam logic [POS_W-1:0] END_POS  = 6'd63;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [WORD_W-1:0] H_INIT [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } item_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

`default_nettype wire

@@ src/sha1md_fifo.sv @@
// Short item queue between the front and the engine.
// Depends on sha1md_pkg for the item type, depth and status struct.
`default_nettype none

module sha1md_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire sha1md_pkg::item_t      push_item,
  input  wire logic                   pop,
  output wire sha1md_pkg::item_t      head,
  output wire sha1md_pkg::q_status_t  status
);

  sha1md_pkg::item_t                  mem_r [sha1md_pkg::Q_DEPTH];
  logic [sha1md_pkg::Q_PTR_W-1:0]     wr_ptr_r;
  logic [sha1md_pkg::Q_PTR_W-1:0]     rd_ptr_r;
  logic [sha1md_pkg::Q_CNT_W-1:0]     count_r;
  logic [sha1md_pkg::Q_CNT_W-1:0]     count_nxt;

  assign head            = mem_r[rd_ptr_r];
  assign status.full     = (count_r == sha1md_pkg::Q_CNT_W'(sha1md_pkg::Q_DEPTH));
  assign status.nonempty = (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/sha1md_front.sv @@
// Input stage: accepts items, drops empty ones, forwards the rest to the queue.
// Depends on sha1md_pkg for the item type and queue status.
`default_nettype none

module sha1md_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output wire logic                   in_ready,
  input  wire logic [7:0]             in_data_byte,
  input  wire logic                   in_byte_present,
  input  wire logic                   in_end_of_message,
  input  wire sha1md_pkg::q_status_t  q_status,
  output wire logic                   push,
  output wire sha1md_pkg::item_t      push_item
);

  sha1md_pkg::item_t item_r;
  logic              valid_r;
  logic              accept;
  logic              keep;

  assign push      = valid_r && !q_status.full;
  assign push_item = item_r;
  assign in_ready  = !valid_r || !q_status.full;
  assign accept    = in_valid && in_ready;
  assign keep      = in_byte_present || in_end_of_message;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data    <= in_data_byte;
      item_r.present <= in_byte_present;
      item_r.eom     <= in_end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (valid_r && !push) || (accept && keep);
    end
  end

endmodule

`default_nettype wire

@@ src/sha1md_engine.sv @@
// Back end: packs bytes into the schedule window, pads, runs 80 rounds, emits digest.
// Depends on sha1md_pkg for constants, the item type and queue status.
`default_nettype none

module sha1md_engine (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sha1md_pkg::item_t      head,
  input  wire sha1md_pkg::q_status_t  q_status,
  output wire logic                   pop,
  output wire logic                   out_valid,
  input  wire logic                   out_ready,
  output wire logic [31:0]            out_digest_word,
  output wire logic [2:0]             out_word_index,
  output wire logic                   out_last_word
);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_PAD,
    S_ROUND,
    S_HADD,
    S_OUT
  } state_t;

  state_t                              state_r;
  logic [sha1md_pkg::WORD_W-1:0]       h_r [sha1md_pkg::NUM_H];
  logic [sha1md_pkg::WORD_W-1:0]       win_r [sha1md_pkg::WIN_DEPTH];
  logic [23:0]                         acc_r;
  logic [sha1md_pkg::POS_W-1:0]        pos_r;
  logic [sha1md_pkg::LEN_W-1:0]        bit_len_r;
  logic [sha1md_pkg::LEN_W-1:0]        len_r;
  logic [sha1md_pkg::RND_W-1:0]        rnd_r;
  logic [sha1md_pkg::IDX_W-1:0]        oidx_r;
  logic                                pad_r;
  logic                                first_r;
  logic                                ok_r;
  logic                                final_r;
  logic [31:0]                         a_r, b_r, c_r, d_r, e_r;
  logic                                out_valid_r;
  logic [31:0]                         out_word_r;
  logic [sha1md_pkg::IDX_W-1:0]        out_index_r;
  logic                                out_last_r;

  logic                                byte_we;
  logic [7:0]                          byte_val;
  logic [31:0]                         word_nxt;
  logic [31:0]                         f_val;
  logic [31:0]                         k_val;
  logic [31:0]                         t_val;
  logic [31:0]                         w_x;
  logic [31:0]                         w_nxt;
  logic [sha1md_pkg::LEN_W-1:0]        bit_len_nxt;

  assign pop             = (state_r == S_COLLECT) && q_status.nonempty;
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_index_r;
  assign out_last_word   = out_last_r;

  always_comb begin
    byte_we  = 1'b0;
    byte_val = head.data;
    case (state_r)
      S_COLLECT: begin
        byte_we = pop && head.present;
      end
      S_PAD: begin
        byte_we = 1'b1;
        if (first_r) begin
          byte_val = sha1md_pkg::PAD_BYTE;
        end else if (ok_r && (pos_r >= sha1md_pkg::LEN_POS)) begin
          byte_val = len_r[63:56];
        end else begin
          byte_val = 8'h00;
        end
      end
      default: begin
        byte_we = 1'b0;
      end
    endcase
  end

  assign word_nxt    = {acc_r, byte_val};
  assign bit_len_nxt = bit_len_r + 64'd8;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1md_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1md_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1md_pkg::K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1md_pkg::K3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + win_r[0] + k_val;
  assign w_x   = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_nxt = {w_x[30:0], w_x[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      for (int i = 0; i < sha1md_pkg::NUM_H; i++) begin
        h_r[i] <= sha1md_pkg::H_INIT[i];
      end
      pos_r       <= '0;
      bit_len_r   <= '0;
      rnd_r       <= '0;
      oidx_r      <= '0;
      pad_r       <= 1'b0;
      first_r     <= 1'b0;
      ok_r        <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (byte_we) begin
        acc_r <= word_nxt[23:0];
        pos_r <= pos_r + 1'b1;
        if (pos_r[1:0] == 2'b11) begin
          for (int i = 0; i < sha1md_pkg::WIN_DEPTH - 1; i++) begin
            win_r[i] <= win_r[i+1];
          end
          win_r[sha1md_pkg::WIN_DEPTH-1] <= word_nxt;
        end
        if (pos_r == sha1md_pkg::END_POS) begin
          a_r     <= h_r[0];
          b_r     <= h_r[1];
          c_r     <= h_r[2];
          d_r     <= h_r[3];
          e_r     <= h_r[4];
          rnd_r   <= '0;
          state_r <= S_ROUND;
        end
      end

      case (state_r)
        S_COLLECT: begin
          if (pop) begin
            if (head.present) begin
              bit_len_r <= bit_len_nxt;
            end
            if (head.eom) begin
              len_r   <= head.present ? bit_len_nxt : bit_len_r;
              pad_r   <= 1'b1;
              first_r <= 1'b1;
              ok_r    <= 1'b0;
              final_r <= 1'b0;
              if (!(head.present && (pos_r == sha1md_pkg::END_POS))) begin
                state_r <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          if (first_r) begin
            first_r <= 1'b0;
            if (pos_r < sha1md_pkg::LEN_POS) begin
              ok_r <= 1'b1;
            end
          end else if (ok_r && (pos_r >= sha1md_pkg::LEN_POS)) begin
            len_r <= {len_r[55:0], 8'h00};
          end
          if (pos_r == sha1md_pkg::END_POS) begin
            if (ok_r) begin
              final_r <= 1'b1;
            end else begin
              ok_r <= 1'b1;
            end
          end
        end
        S_ROUND: begin
          a_r <= t_val;
          b_r <= a_r;
          c_r <= {b_r[1:0], b_r[31:2]};
          d_r <= c_r;
          e_r <= d_r;
          for (int i = 0; i < sha1md_pkg::WIN_DEPTH - 1; i++) begin
            win_r[i] <= win_r[i+1];
          end
          win_r[sha1md_pkg::WIN_DEPTH-1] <= w_nxt;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS - 1)) begin
            state_r <= S_HADD;
          end
        end
        S_HADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          if (final_r) begin
            state_r <= S_OUT;
          end else if (pad_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_COLLECT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_word_r  <= h_r[oidx_r];
            out_index_r <= oidx_r;
            out_last_r  <= (oidx_r == sha1md_pkg::LAST_IDX);
            out_valid_r <= 1'b1;
            oidx_r      <= oidx_r + 1'b1;
            if (oidx_r == sha1md_pkg::LAST_IDX) begin
              for (int i = 0; i < sha1md_pkg::NUM_H; i++) begin
                h_r[i] <= sha1md_pkg::H_INIT[i];
              end
              bit_len_r <= '0;
              pad_r     <= 1'b0;
              final_r   <= 1'b0;
              oidx_r    <= '0;
              state_r   <= S_COLLECT;
            end
          end
        end
        default: begin
          state_r <= S_COLLECT;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (rnd_r < sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS)))
    else $error("round counter out of range");

  a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (pos_r == '0))
    else $error("digest output with a partly filled block");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_index_r == sha1md_pkg::LAST_IDX))
    else $error("last word flag on wrong index");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |=> !$past(pop))
    else $error("item taken during compression");
`endif

endmodule

`default_nettype wire

@@ src/sha1_message_digest_core.sv @@
// SHA-1 message digest core, one message byte per transfer.
// Per 64-byte block: bytes fill the schedule window, then 80 rounds and one add step run.
// Sustained rate is set by the round loop; no bytes leave the queue during the rounds.
// End of message: padding and length take up to two compressions, then five words.
// Synchronous active-low reset loads the initial chaining words; no clearing pass.
`default_nettype none

module sha1_message_digest_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output wire logic        in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output wire logic        out_valid,
  input  wire logic        out_ready,
  output wire logic [31:0] out_digest_word,
  output wire logic [2:0]  out_word_index,
  output wire logic        out_last_word
);

  sha1md_pkg::item_t      push_item;
  sha1md_pkg::item_t      head;
  sha1md_pkg::q_status_t  q_status;
  logic                   push;
  logic                   pop;

  sha1md_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .q_status          (q_status),
    .push              (push),
    .push_item         (push_item)
  );

  sha1md_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  sha1md_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire
